[design/rc4_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_pkg: shared types and constants for the RC4 keystream engine
// Word formats of both channels, permutation RAM request and code values.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int unsigned PERM_SIZE         = 256;
    localparam int unsigned MAX_KEY_BYTES_DEF = 256;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       last_out;
    } t_out_word;

    typedef struct packed {
        logic [7:0] rd_addr;
        logic       we;
        logic [7:0] wr_addr;
        logic [7:0] wr_data;
        logic       clear;
    } t_perm_req;

endpackage

[design/rc4_add_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_add_unit: shared modulo-256 adder
// Three-operand byte add used for i, j and keystream index updates.
// ----------------------------------------------------------------------------
module rc4_add_unit (
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    input  logic [7:0] i_c,
    output logic [7:0] o_sum
);

    assign o_sum = i_a + i_b + i_c;

endmodule

[design/rc4_perm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_perm_ram: 256 x 8 permutation store
// One write and one registered read per cycle. Per-entry valid bits make an
// unwritten entry read as its own address, so a clear restores identity.
// ----------------------------------------------------------------------------
module rc4_perm_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rc4_pkg::t_perm_req i_req,
    output logic [7:0]        o_rd_data
);

    logic [7:0]                   r_mem [rc4_pkg::PERM_SIZE];
    logic [rc4_pkg::PERM_SIZE-1:0] r_valid;
    logic [7:0]                   r_rd_data;
    logic [7:0]                   r_rd_addr;
    logic                         r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_req.rd_addr];
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.we) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
        r_rd_addr <= i_req.rd_addr;
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : r_rd_addr;

endmodule

[design/rc4_key_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_key_ram: key byte store
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rc4_key_ram #(
    parameter int unsigned DEPTH = rc4_pkg::MAX_KEY_BYTES_DEF,
    parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [7:0]       i_wr_data,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [7:0]       o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/rc4_keystream_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_keystream_cipher: byte-wide RC4 engine
// Collects key bytes, runs the key schedule and XORs data with keystream.
// ----------------------------------------------------------------------------
// Usage: send key bytes (kind = 0) one word at a time; each is stored, and
// bytes past MAX_KEY_BYTES are dropped. The key word marked last starts the
// key schedule, which clears back to the identity permutation and then
// runs 256 swap steps; the input is not ready again until it ends. A data
// word (kind = 1) is carried to a loaded result before the next word is
// taken; the result word carries the input byte XOR keystream and the
// input last flag. This pace is set by the single read and single write
// port of the permutation RAM: a schedule step needs two dependent reads
// and two writes in sequence, a keystream step three dependent reads and
// two writes. A finished result waits in the output register while the
// next word is accepted; a key word produces no result.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher #(
    parameter int unsigned MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rc4_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rc4_pkg::t_out_word o_out_word
);

    localparam int unsigned KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam logic [7:0]  K_LAST = 8'(rc4_pkg::PERM_SIZE - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_START,
        ST_KS_RD,
        ST_KS_GETK,
        ST_KS_GETJ,
        ST_KS_WRJ,
        ST_D_GETI,
        ST_D_GETJ,
        ST_D_WRJ,
        ST_D_RDT,
        ST_D_OUT
    } t_state;

    t_state               r_state, n_state;
    logic [7:0]           r_i, n_i;
    logic [7:0]           r_j, n_j;
    logic [7:0]           r_k, n_k;
    logic [KIDX_W-1:0]    r_ki, n_ki;
    logic [CNT_W-1:0]     r_key_count, n_key_count;
    logic [CNT_W-1:0]     r_key_len, n_key_len;
    logic [7:0]           r_sa, n_sa;
    logic [7:0]           r_sb, n_sb;
    logic [7:0]           r_value, n_value;
    logic                 r_last, n_last;
    logic                 r_out_valid, n_out_valid;
    rc4_pkg::t_out_word   r_out_word, n_out_word;

    rc4_pkg::t_perm_req   perm_req;
    logic [7:0]           perm_rd;
    logic                 key_we;
    logic [KIDX_W-1:0]    key_rd_addr;
    logic [7:0]           key_rd;
    logic [7:0]           add_a, add_b, add_c, add_sum;
    logic                 in_fire;
    logic                 key_room;
    logic                 out_free;

    rc4_perm_ram u_perm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (perm_req),
        .o_rd_data (perm_rd)
    );

    rc4_key_ram #(
        .DEPTH (MAX_KEY_BYTES),
        .IDX_W (KIDX_W)
    ) u_key (
        .i_clk     (i_clk),
        .i_we      (key_we),
        .i_wr_addr (r_key_count[KIDX_W-1:0]),
        .i_wr_data (i_in_word.value),
        .i_rd_addr (key_rd_addr),
        .o_rd_data (key_rd)
    );

    rc4_add_unit u_add (
        .i_a   (add_a),
        .i_b   (add_b),
        .i_c   (add_c),
        .o_sum (add_sum)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign key_room    = (r_key_count < CNT_W'(MAX_KEY_BYTES));
    assign key_we      = in_fire && (i_in_word.kind == rc4_pkg::KIND_KEY) && key_room;
    assign key_rd_addr = r_ki;
    assign out_free    = !r_out_valid || i_out_ready;

    // Route the shared adder: i + 1, j + S[i], j + S[k] + key, S[i] + S[j].
    always_comb begin
        add_a = 8'd0;
        add_b = 8'd0;
        add_c = 8'd0;
        unique case (r_state)
            ST_IDLE: begin
                add_a = r_i;
                add_b = 8'd1;
            end
            ST_KS_GETK: begin
                add_a = r_j;
                add_b = perm_rd;
                add_c = key_rd;
            end
            ST_D_GETI: begin
                add_a = r_j;
                add_b = perm_rd;
            end
            ST_D_RDT, ST_D_OUT: begin
                add_a = r_sa;
                add_b = r_sb;
            end
            default: begin
                add_a = 8'd0;
            end
        endcase
    end

    // Sequencer: next state, permutation RAM requests and datapath registers.
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_ki        = r_ki;
        n_key_count = r_key_count;
        n_key_len   = r_key_len;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_value     = r_value;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;

        perm_req         = '0;
        perm_req.rd_addr = r_k;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in_word.kind == rc4_pkg::KIND_KEY) begin
                        // Store the byte if there is room, start schedule on last.
                        if (key_room) begin
                            n_key_count = r_key_count + CNT_W'(1);
                        end
                        if (i_in_word.last) begin
                            n_key_len   = key_room ? (r_key_count + CNT_W'(1)) : r_key_count;
                            n_key_count = '0;
                            n_state     = ST_KS_START;
                        end
                    end else begin
                        // Advance i and fetch S[i].
                        n_i              = add_sum;
                        n_value          = i_in_word.value;
                        n_last           = i_in_word.last;
                        perm_req.rd_addr = add_sum;
                        n_state          = ST_D_GETI;
                    end
                end
            end
            ST_KS_START: begin
                perm_req.clear = 1'b1;
                n_k            = 8'd0;
                n_j            = 8'd0;
                n_ki           = '0;
                n_state        = ST_KS_RD;
            end
            ST_KS_RD: begin
                perm_req.rd_addr = r_k;
                n_state          = ST_KS_GETK;
            end
            ST_KS_GETK: begin
                n_sa             = perm_rd;
                n_j              = add_sum;
                perm_req.rd_addr = add_sum;
                n_state          = ST_KS_GETJ;
            end
            ST_KS_GETJ: begin
                perm_req.we      = 1'b1;
                perm_req.wr_addr = r_k;
                perm_req.wr_data = perm_rd;
                n_state          = ST_KS_WRJ;
            end
            ST_KS_WRJ: begin
                perm_req.we      = 1'b1;
                perm_req.wr_addr = r_j;
                perm_req.wr_data = r_sa;
                n_k              = r_k + 8'd1;
                // Repeat the key: wrap the key index at the key length.
                if ((CNT_W'(r_ki) + CNT_W'(1)) == r_key_len) begin
                    n_ki = '0;
                end else begin
                    n_ki = r_ki + KIDX_W'(1);
                end
                if (r_k == K_LAST) begin
                    n_i     = 8'd0;
                    n_j     = 8'd0;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_KS_RD;
                end
            end
            ST_D_GETI: begin
                n_sa             = perm_rd;
                n_j              = add_sum;
                perm_req.rd_addr = add_sum;
                n_state          = ST_D_GETJ;
            end
            ST_D_GETJ: begin
                n_sb             = perm_rd;
                perm_req.we      = 1'b1;
                perm_req.wr_addr = r_i;
                perm_req.wr_data = perm_rd;
                n_state          = ST_D_WRJ;
            end
            ST_D_WRJ: begin
                perm_req.we      = 1'b1;
                perm_req.wr_addr = r_j;
                perm_req.wr_data = r_sa;
                n_state          = ST_D_RDT;
            end
            ST_D_RDT: begin
                perm_req.rd_addr = add_sum;
                n_state          = ST_D_OUT;
            end
            ST_D_OUT: begin
                // Keep reading S[S[i] + S[j]] while the output register is full.
                perm_req.rd_addr = add_sum;
                if (out_free) begin
                    n_out_word.result_byte = r_value ^ perm_rd;
                    n_out_word.last_out    = r_last;
                    n_out_valid            = 1'b1;
                    n_state                = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= 8'd0;
            r_j         <= 8'd0;
            r_k         <= 8'd0;
            r_ki        <= '0;
            r_key_count <= '0;
            r_key_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_ki        <= n_ki;
            r_key_count <= n_key_count;
            r_key_len   <= n_key_len;
            r_out_valid <= n_out_valid;
        end
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_value    <= n_value;
        r_last     <= n_last;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
